/* sv/bra_pkg.sv */
// Bitmap run allocator: shared constants and action codes.
// Used by the channel interfaces and the top level; no dependencies.

package bra_pkg;

	localparam int MAP_BITS   = 1024;
	localparam int WORD_BITS  = 32;
	localparam int WORD_COUNT = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_AW    = $clog2(WORD_COUNT);
	localparam int BIT_AW     = $clog2(WORD_BITS);

	localparam int ACT_W = 2;
	localparam int IDX_W = 10;
	localparam int LEN_W = 11;
	localparam int CFG_W = 8;

	localparam logic [CFG_W-1:0] MAP_BYTES_RESET = 8'd128;

	localparam logic [ACT_W-1:0] ACT_TEST  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FIND  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd3;

endpackage

/* sv/bra_req_if.sv */
// Request channel of the bitmap run allocator: valid/ready plus request fields.
// Depends on bra_pkg.

interface bra_req_if;
	import bra_pkg::*;

	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] action;
	logic [IDX_W-1:0] bit_index;
	logic             bit_value;
	logic [LEN_W-1:0] run_length;

	modport source (output valid, output action, output bit_index, output bit_value,
		output run_length, input ready);
	modport sink (input valid, input action, input bit_index, input bit_value,
		input run_length, output ready);
endinterface

/* sv/bra_rsp_if.sv */
// Response channel of the bitmap run allocator: valid/ready plus result fields.
// Depends on bra_pkg.

interface bra_rsp_if;
	import bra_pkg::*;

	logic             valid;
	logic             ready;
	logic             bit_is_set;
	logic             run_found;
	logic [IDX_W-1:0] run_start;

	modport source (output valid, output bit_is_set, output run_found, output run_start,
		input ready);
	modport sink (input valid, input bit_is_set, input run_found, input run_start,
		output ready);
endinterface

/* sv/bra_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module bra_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* sv/bitmap_run_allocator_top.sv */
// Bitmap run allocator top level: occupancy map in one RAM, sequencer for
// test, write, clear-all and first-fit free-run search. Depends on bra_pkg,
// bra_req_if, bra_rsp_if and bra_ram.
//
//   channel   dir  handshake           contents
//   req       in   valid/ready         action, bit_index, bit_value, run_length
//   rsp       out  valid/ready         bit_is_set, run_found, run_start
//   cfg       in   cfg_we              cfg_wdata = map_bytes
//
// One item at a time. Test and write go through accept, RAM read and result
// on their way to the output register; clear-all goes from accept to result;
// find scans one map word per cycle, up to the last word of the region, a rate
// set by the read port of the map RAM. A zero or oversize run length skips it.
// Reset clears the per-word valid bits at once, so no clearing pass is needed;
// clear-all clears them when accepted. The output register lets the next item
// in while a result waits; a result finished behind an unread one holds.

module bitmap_run_allocator_top (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [bra_pkg::CFG_W-1:0] cfg_wdata,
	bra_req_if.sink                 req,
	bra_rsp_if.source               rsp
);
	import bra_pkg::*;

	localparam int REG_W = CFG_W + 3;
	localparam int RUN_W = LEN_W + 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	function automatic logic [BIT_AW-1:0] hi_set(input logic [WORD_BITS-1:0] v);
		logic [BIT_AW-1:0] r;
		r = '0;
		for (int k = 0; k < WORD_BITS; k++) begin
			if (v[k]) r = BIT_AW'(k);
		end
		return r;
	endfunction

	function automatic logic [BIT_AW-1:0] lo_set(input logic [WORD_BITS-1:0] v);
		logic [BIT_AW-1:0] r;
		r = '0;
		for (int k = WORD_BITS - 1; k >= 0; k--) begin
			if (v[k]) r = BIT_AW'(k);
		end
		return r;
	endfunction

	logic [1:0]            state_q;
	logic [CFG_W-1:0]      map_bytes_q;
	logic [WORD_COUNT-1:0] valid_q;
	logic [ACT_W-1:0]      act_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  val_q;
	logic [LEN_W-1:0]      len_q;
	logic [WORD_AW-1:0]    word_q;
	logic [WORD_AW-1:0]    last_q;
	logic [BIT_AW-1:0]     tail_q;
	logic [LEN_W-1:0]      cnt_q;
	logic                  res_set_q;
	logic                  res_found_q;
	logic [IDX_W-1:0]      res_start_q;
	logic                  out_valid_q;
	logic                  out_set_q;
	logic                  out_found_q;
	logic [IDX_W-1:0]      out_start_q;
	logic [WORD_AW-1:0]    raddr_s1;

	// region size and its word bounds
	logic [REG_W-1:0]      region_full;
	logic [REG_W-1:0]      region;
	logic [REG_W-1:0]      region_m1;
	logic                  skip_find;

	always_comb begin
		region_full = {map_bytes_q, 3'b000};
		region      = (region_full > REG_W'(MAP_BITS)) ? REG_W'(MAP_BITS) : region_full;
		region_m1   = region - REG_W'(1);
		skip_find   = (req.run_length == '0) || (region == '0)
			|| (REG_W'(req.run_length) > region);
	end

	// map RAM
	logic                  accept;
	logic                  ram_we;
	logic [WORD_AW-1:0]    ram_waddr;
	logic [WORD_BITS-1:0]  ram_wdata;
	logic [WORD_AW-1:0]    ram_raddr;
	logic [WORD_BITS-1:0]  ram_rdata;
	logic [WORD_BITS-1:0]  rd_word;
	logic                  load_out;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	always_comb begin
		if (state_q == S_IDLE) begin
			ram_raddr = (req.action == ACT_FIND) ? '0 : req.bit_index[IDX_W-1:BIT_AW];
		end else begin
			ram_raddr = word_q + WORD_AW'(1);
		end
	end

	// a word never written since reset or clear-all reads as free
	assign rd_word   = valid_q[raddr_s1] ? ram_rdata : '0;
	assign ram_we    = (state_q == S_READ) && (act_q == ACT_WRITE);
	assign ram_waddr = idx_q[IDX_W-1:BIT_AW];

	always_comb begin
		ram_wdata = rd_word;
		ram_wdata[idx_q[BIT_AW-1:0]] = val_q;
	end

	bra_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (WORD_COUNT)
	) u_map_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// one word of the search: bits outside the region count as occupied
	logic [WORD_BITS-1:0]  tail_mask;
	logic [WORD_BITS-1:0]  occ;
	logic [WORD_BITS-1:0]  below;
	logic [RUN_W-1:0]      run;
	logic [WORD_BITS-1:0]  hit;
	logic [BIT_AW-1:0]     hit_pos;
	logic [RUN_W-1:0]      start_full;
	logic [LEN_W-1:0]      cnt_next;

	always_comb begin
		tail_mask = (tail_q == '0) ? '1 : ((WORD_BITS'(1) << tail_q) - WORD_BITS'(1));
		occ       = rd_word | ((word_q == last_q) ? ~tail_mask : '0);
		hit       = '0;
		below     = '0;
		run       = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			below = occ & ({WORD_BITS{1'b1}} >> (WORD_BITS - 1 - j));
			if (below == '0) begin
				run = RUN_W'(cnt_q) + RUN_W'(j + 1);
			end else begin
				run = RUN_W'(j) - RUN_W'(hi_set(below));
			end
			hit[j] = !occ[j] && (run >= RUN_W'(len_q));
		end
		hit_pos    = lo_set(hit);
		start_full = RUN_W'({word_q, hit_pos}) + RUN_W'(1) - RUN_W'(len_q);
		if (occ == '0) begin
			cnt_next = cnt_q + LEN_W'(WORD_BITS);
		end else begin
			cnt_next = LEN_W'(WORD_BITS - 1) - LEN_W'(hi_set(occ));
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			map_bytes_q <= MAP_BYTES_RESET;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				map_bytes_q <= cfg_wdata;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req.action)
							ACT_TEST, ACT_WRITE: state_q <= S_READ;
							ACT_FIND: state_q <= skip_find ? S_DONE : S_SCAN;
							ACT_CLEAR: begin
								valid_q <= '0;
								state_q <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_READ: state_q <= S_DONE;
				S_SCAN: begin
					if ((hit != '0) || (word_q == last_q)) state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		raddr_s1 <= ram_raddr;
		if (accept) begin
			act_q       <= req.action;
			idx_q       <= req.bit_index;
			val_q       <= req.bit_value;
			len_q       <= req.run_length;
			word_q      <= '0;
			cnt_q       <= '0;
			last_q      <= region_m1[IDX_W-1:BIT_AW];
			tail_q      <= region[BIT_AW-1:0];
			res_set_q   <= 1'b0;
			res_found_q <= 1'b0;
			res_start_q <= '0;
		end
		if ((state_q == S_READ) && (act_q == ACT_TEST)) begin
			res_set_q <= rd_word[idx_q[BIT_AW-1:0]];
		end
		if (state_q == S_SCAN) begin
			if (hit != '0) begin
				res_found_q <= 1'b1;
				res_start_q <= start_full[IDX_W-1:0];
			end else begin
				word_q <= word_q + WORD_AW'(1);
				cnt_q  <= cnt_next;
			end
		end
		if (load_out) begin
			out_set_q   <= res_set_q;
			out_found_q <= res_found_q;
			out_start_q <= res_start_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.bit_is_set = out_set_q;
	assign rsp.run_found  = out_found_q;
	assign rsp.run_start  = out_start_q;

	// checks
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (word_q <= last_q))
		else $error("search passed the last word of the region");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("sequencer idle right after taking an item");

	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.action == ACT_CLEAR)) |=> (valid_q == '0))
		else $error("clear-all left a word marked written");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (rsp.valid && (state_q == S_IDLE)))
		else $error("finished result not presented");
endmodule
